FILE: hw/rtl/spt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superellipse point test package
// widths, register codes, word types and the exp2 factor table
// ----------------------------------------------------------------------------
package spt_pkg;

  // pixel coordinate width, valid from 8 to 16
  localparam int COORD_BITS     = 10;
  localparam int AXIS_BITS      = 10;
  localparam int EXPO_BITS      = 16;
  localparam int EXPO_FRAC_BITS = 12;
  localparam int TOL_BITS       = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // log2 results are q4.16, enough for any input below 2^16
  localparam int LOG_INT_BITS   = 4;
  localparam int LOG_FRAC_BITS  = 16;
  localparam int LOG_BITS       = LOG_INT_BITS + LOG_FRAC_BITS;
  localparam int DIFF_BITS      = LOG_BITS + 1;

  // one term saturates at 2.0 in q16
  localparam int TERM_BITS      = 18;
  localparam int SUM_BITS       = TERM_BITS + 1;
  localparam logic [TERM_BITS-1:0] ONE_Q16 = 18'd65536;
  localparam logic [TERM_BITS-1:0] TWO_Q16 = 18'd131072;

  // pipeline depths
  localparam int LOG_STAGES  = LOG_FRAC_BITS + 1;
  localparam int EXP_STEPS   = LOG_FRAC_BITS;
  localparam int TERM_STAGES = EXP_STEPS + 3;
  localparam int DIFF_AT     = LOG_STAGES + 1;
  localparam int LAST_AT     = DIFF_AT + TERM_STAGES + 1;

  // configuration register codes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEMI_AXIS_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEMI_AXIS_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT_X  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT_Y  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y    = 3'd6;

  // reset values
  localparam logic [AXIS_BITS-1:0]  RST_SEMI_AXIS = 10'd250;
  localparam logic [EXPO_BITS-1:0]  RST_EXPONENT  = 16'd8192;
  localparam logic [TOL_BITS-1:0]   RST_TOLERANCE = 16'd66;
  localparam logic [AXIS_BITS-1:0]  RST_CENTER    = 10'd500;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  on_curve;
  } pixel_out_t;

  // bitwise integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factors 2^(2^-(j+1)) in q2.30, each the truncated root of the one before
  function automatic logic [EXP_STEPS-1:0][31:0] build_exp2_factors();
    logic [EXP_STEPS-1:0][31:0] f;
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int j = 0; j < EXP_STEPS; j++) begin
      c = isqrt64(c << 30);
      f[j] = c[31:0];
    end
    return f;
  endfunction

  localparam logic [EXP_STEPS-1:0][31:0] EXP2_FACTOR = build_exp2_factors();

endpackage

FILE: hw/rtl/spt_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_log2
// pipelined log2 in q4.16: normalize, then one mantissa squaring per stage
// ----------------------------------------------------------------------------
module spt_log2 #(
  parameter int IN_BITS = spt_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [IN_BITS-1:0]           value,
  output logic [spt_pkg::LOG_BITS-1:0] log_q16
);
  import spt_pkg::*;

  typedef struct packed {
    logic [LOG_INT_BITS-1:0]  k;
    logic [LOG_FRAC_BITS-1:0] fr;
    logic [31:0]              mant;
  } log_st_t;

  log_st_t                 st [LOG_STAGES];
  log_st_t                 norm;
  logic [LOG_INT_BITS-1:0] k;
  logic [4:0]              sh;

  // square the q1.31 mantissa, renormalize and take one fraction bit
  function automatic log_st_t log_step(input log_st_t s);
    logic [63:0] sq;
    logic [32:0] m2;
    log_st_t     n;
    sq   = 64'(s.mant) * 64'(s.mant);
    m2   = sq[63:31];
    n.k  = s.k;
    if (m2[32]) begin
      n.mant = m2[32:1];
      n.fr   = {s.fr[LOG_FRAC_BITS-2:0], 1'b1};
    end else begin
      n.mant = m2[31:0];
      n.fr   = {s.fr[LOG_FRAC_BITS-2:0], 1'b0};
    end
    return n;
  endfunction

  // top set bit
  always_comb begin
    k = '0;
    for (int i = 0; i < IN_BITS; i++) begin
      if (value[i]) k = LOG_INT_BITS'(i);
    end
    sh        = 5'd31 - 5'(k);
    norm.k    = k;
    norm.fr   = '0;
    norm.mant = 32'(value) << sh;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= norm;
      for (int i = 1; i < LOG_STAGES; i++) begin
        st[i] <= log_step(st[i-1]);
      end
    end
  end

  assign log_q16 = {st[LOG_STAGES-1].k, st[LOG_STAGES-1].fr};

endmodule

FILE: hw/rtl/spt_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_term
// one curve term: exp2(exponent * log difference), saturating at 2.0
// ----------------------------------------------------------------------------
module spt_term (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [spt_pkg::DIFF_BITS-1:0] diff,
  input  logic                                dist_zero,
  input  logic [spt_pkg::EXPO_BITS-1:0]       expo,
  output logic [spt_pkg::TERM_BITS-1:0]       term
);
  import spt_pkg::*;

  localparam int PROD_BITS = DIFF_BITS + EXPO_BITS + 1;
  localparam int T_BITS    = PROD_BITS - EXPO_FRAC_BITS;
  localparam int EXP_BIAS  = 17 * 65536;

  typedef struct packed {
    logic [31:0]              r;
    logic [LOG_FRAC_BITS-1:0] frac;
    logic [4:0]               shift;
    logic                     sat;
    logic                     under;
    logic                     zero;
  } exp_st_t;

  logic signed [PROD_BITS-1:0] prod;
  logic                        prod_zero;
  logic signed [T_BITS-1:0]    t;
  logic signed [T_BITS-1:0]    u;
  exp_st_t                     b_st;
  exp_st_t                     st [EXP_STEPS+1];
  logic [31:0]                 shifted;
  logic [TERM_BITS-1:0]        term_next;

  // multiply in one q2.30 factor when its fraction bit is set
  function automatic exp_st_t exp_step(input exp_st_t s, input logic [31:0] c,
                                       input logic take);
    logic [63:0] pr;
    exp_st_t     n;
    n  = s;
    pr = 64'(s.r) * 64'(c);
    if (take) n.r = pr[61:30];
    return n;
  endfunction

  // floor shift to q16, split into integer and fraction
  always_comb begin
    t          = $signed(prod[PROD_BITS-1:EXPO_FRAC_BITS]);
    u          = t + T_BITS'(EXP_BIAS);
    b_st.r     = 32'h4000_0000;
    b_st.frac  = u[LOG_FRAC_BITS-1:0];
    b_st.shift = 5'd31 - u[LOG_FRAC_BITS+4:LOG_FRAC_BITS];
    b_st.sat   = (t >= 65536);
    b_st.under = (t < -EXP_BIAS);
    b_st.zero  = prod_zero;
  end

  always_comb begin
    shifted = st[EXP_STEPS].r >> st[EXP_STEPS].shift;
    if (expo == '0) begin
      term_next = ONE_Q16;
    end else if (st[EXP_STEPS].zero) begin
      term_next = '0;
    end else if (st[EXP_STEPS].sat) begin
      term_next = TWO_Q16;
    end else if (st[EXP_STEPS].under) begin
      term_next = '0;
    end else if (shifted > 32'(TWO_Q16)) begin
      term_next = TWO_Q16;
    end else begin
      term_next = shifted[TERM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod      <= PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, expo}));
      prod_zero <= dist_zero;
      st[0]     <= b_st;
      for (int j = 1; j <= EXP_STEPS; j++) begin
        st[j] <= exp_step(st[j-1], EXP2_FACTOR[j-1], st[j-1].frac[EXP_STEPS-j]);
      end
      term <= term_next;
    end
  end

endmodule

FILE: hw/rtl/superellipse_point_test.sv
`timescale 1ns / 1ps
// a pixel word passes the input and offset stages, the 17-stage log2 and
// 19-stage exp2 term chains, then the difference, compare and output registers
// throughput: one word per cycle while the skid stage is empty, every stage is pipelined
// a stalled result is held in the output register and one more in a skid stage
// reset: synchronous, active high; clears valid bits and restores the register defaults
// ----------------------------------------------------------------------------
// superellipse_point_test
// tests pixels against |dx/a|^m + |dy/b|^n = 1 within a tolerance
// ----------------------------------------------------------------------------
module superellipse_point_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  spt_pkg::pixel_in_t                 pixel,
  output logic                               result_valid,
  input  logic                               result_ready,
  output spt_pkg::pixel_out_t                result,
  input  logic                               cfg_write,
  input  logic [spt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [spt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import spt_pkg::*;

  // side info that rides along with each word
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  zero_x;
    logic                  zero_y;
  } tag_t;

  // configuration registers
  logic [AXIS_BITS-1:0] semi_axis_x;
  logic [AXIS_BITS-1:0] semi_axis_y;
  logic [EXPO_BITS-1:0] exponent_x;
  logic [EXPO_BITS-1:0] exponent_y;
  logic [TOL_BITS-1:0]  tolerance;
  logic [AXIS_BITS-1:0] center_x;
  logic [AXIS_BITS-1:0] center_y;

  // pipeline control
  logic                 adv;
  logic                 skid_valid;
  pixel_out_t           skid;
  logic                 push;
  pixel_out_t           push_word;

  // input stage
  logic                 s0_valid;
  pixel_in_t            s0_pix;

  // offset stage
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [COORD_BITS-1:0] dx_next;
  logic [COORD_BITS-1:0] dy_next;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [AXIS_BITS-1:0]  axis_x;
  logic [AXIS_BITS-1:0]  axis_y;

  // tag line, one entry per stage from the offset stage on
  tag_t                 tag [LAST_AT+1];
  logic [LAST_AT:0]     vld;

  logic [LOG_BITS-1:0]          log_dx;
  logic [LOG_BITS-1:0]          log_dy;
  logic [LOG_BITS-1:0]          log_ax;
  logic [LOG_BITS-1:0]          log_ay;
  logic signed [DIFF_BITS-1:0]  diff_x;
  logic signed [DIFF_BITS-1:0]  diff_y;
  logic [TERM_BITS-1:0]         term_x;
  logic [TERM_BITS-1:0]         term_y;
  logic [SUM_BITS-1:0]          sum;
  logic [SUM_BITS-1:0]          dev;
  logic                         on_curve;

  // ---------------------------------------------------------------------------
  // configuration writes, unknown codes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      semi_axis_x <= RST_SEMI_AXIS;
      semi_axis_y <= RST_SEMI_AXIS;
      exponent_x  <= RST_EXPONENT;
      exponent_y  <= RST_EXPONENT;
      tolerance   <= RST_TOLERANCE;
      center_x    <= RST_CENTER;
      center_y    <= RST_CENTER;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEMI_AXIS_X: semi_axis_x <= cfg_data[AXIS_BITS-1:0];
        REG_SEMI_AXIS_Y: semi_axis_y <= cfg_data[AXIS_BITS-1:0];
        REG_EXPONENT_X:  exponent_x  <= cfg_data[EXPO_BITS-1:0];
        REG_EXPONENT_Y:  exponent_y  <= cfg_data[EXPO_BITS-1:0];
        REG_TOLERANCE:   tolerance   <= cfg_data[TOL_BITS-1:0];
        REG_CENTER_X:    center_x    <= cfg_data[AXIS_BITS-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[AXIS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // whole pipeline moves together; it only halts once the skid stage is full,
  // so a new word is still taken while a finished word waits at the output
  // ---------------------------------------------------------------------------
  assign adv         = !skid_valid;
  assign pixel_ready = adv;

  // center wraps to the coordinate width, a zero axis counts as one
  assign cx      = COORD_BITS'(center_x);
  assign cy      = COORD_BITS'(center_y);
  assign dx_next = (s0_pix.px >= cx) ? s0_pix.px - cx : cx - s0_pix.px;
  assign dy_next = (s0_pix.py >= cy) ? s0_pix.py - cy : cy - s0_pix.py;
  assign axis_x  = (semi_axis_x == '0) ? AXIS_BITS'(1) : semi_axis_x;
  assign axis_y  = (semi_axis_y == '0) ? AXIS_BITS'(1) : semi_axis_y;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      vld      <= '0;
    end else if (adv) begin
      s0_valid <= pixel_valid;
      vld      <= {vld[LAST_AT-1:0], s0_valid};
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_pix        <= pixel;
      dx            <= dx_next;
      dy            <= dy_next;
      tag[0].px     <= s0_pix.px;
      tag[0].py     <= s0_pix.py;
      tag[0].zero_x <= (dx_next == '0);
      tag[0].zero_y <= (dy_next == '0);
      for (int i = 1; i <= LAST_AT; i++) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // log2 of the offsets and the semi-axes
  // ---------------------------------------------------------------------------
  spt_log2 #(.IN_BITS(COORD_BITS)) u_log_dx (
    .clk(clk), .adv(adv), .value(dx), .log_q16(log_dx)
  );

  spt_log2 #(.IN_BITS(COORD_BITS)) u_log_dy (
    .clk(clk), .adv(adv), .value(dy), .log_q16(log_dy)
  );

  // the user must change the semi-axes only while the block is empty; the block does not enforce it
  spt_log2 #(.IN_BITS(AXIS_BITS)) u_log_ax (
    .clk(clk), .adv(adv), .value(axis_x), .log_q16(log_ax)
  );

  spt_log2 #(.IN_BITS(AXIS_BITS)) u_log_ay (
    .clk(clk), .adv(adv), .value(axis_y), .log_q16(log_ay)
  );

  // log difference, lines up with tag[DIFF_AT]
  always_ff @(posedge clk) begin
    if (adv) begin
      diff_x <= $signed({1'b0, log_dx}) - $signed({1'b0, log_ax});
      diff_y <= $signed({1'b0, log_dy}) - $signed({1'b0, log_ay});
    end
  end

  // ---------------------------------------------------------------------------
  // terms, each lines up with tag[LAST_AT-1]
  // ---------------------------------------------------------------------------
  spt_term u_term_x (
    .clk(clk), .adv(adv), .diff(diff_x), .dist_zero(tag[DIFF_AT].zero_x),
    .expo(exponent_x), .term(term_x)
  );

  spt_term u_term_y (
    .clk(clk), .adv(adv), .diff(diff_y), .dist_zero(tag[DIFF_AT].zero_y),
    .expo(exponent_y), .term(term_y)
  );

  // sum and tolerance compare
  assign sum = SUM_BITS'(term_x) + SUM_BITS'(term_y);
  assign dev = (sum >= SUM_BITS'(ONE_Q16)) ? sum - SUM_BITS'(ONE_Q16)
                                           : SUM_BITS'(ONE_Q16) - sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      on_curve <= (dev <= SUM_BITS'(tolerance));
    end
  end

  // ---------------------------------------------------------------------------
  // output register with one skid word behind it
  // ---------------------------------------------------------------------------
  assign push               = adv && vld[LAST_AT];
  assign push_word.pixel_x  = tag[LAST_AT].px;
  assign push_word.pixel_y  = tag[LAST_AT].py;
  assign push_word.on_curve = on_curve;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      // pipeline halted, drain the skid word first
      if (result_ready) begin
        result     <= skid;
        skid_valid <= 1'b0;
      end
    end else if (result_valid && !result_ready) begin
      // output blocked, park the arriving word
      if (push) begin
        skid       <= push_word;
        skid_valid <= 1'b1;
      end
    end else begin
      result_valid <= push;
      if (push) result <= push_word;
    end
  end

endmodule

FILE: hw/rtl/spt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_checker
// port-level checks on the superellipse point test handshakes
// ----------------------------------------------------------------------------
module spt_checker (
  input logic                clk,
  input logic                rst,
  input logic                pixel_ready,
  input logic                result_valid,
  input logic                result_ready,
  input spt_pkg::pixel_out_t result
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // input only backs off while a result word is waiting
  assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> result_valid)
    else $error("pixel_ready low with no result waiting");

  // a taken result always frees the input side
  assert property (@(posedge clk) disable iff (rst)
    result_ready |=> pixel_ready)
    else $error("pixel_ready low after result_ready");

  // input backs off only after a stalled output cycle
  assert property (@(posedge clk) disable iff (rst)
    $fell(pixel_ready) |-> $past(result_valid && !result_ready))
    else $error("pixel_ready fell without an output stall");

endmodule

bind superellipse_point_test spt_checker u_spt_checker (
  .clk(clk),
  .rst(rst),
  .pixel_ready(pixel_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result(result)
);
